### rtl/hbrp_pkg.sv
package hbrp_pkg;

    localparam int SIZE_W = 63;
    localparam int VAL_W = 64;
    localparam int CNT_W = 5;
    localparam int PCNT_W = 3;
    localparam logic [CNT_W-1:0] MAX_DIGITS = 5'd19;
    localparam logic [PCNT_W-1:0] PREFIX_LAST = 3'd5;

    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_DASH = "-";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CASE_GAP = 8'd32;

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_PREFIX = 5'b00010,
        PH_FIRST  = 5'b00100,
        PH_SECOND = 5'b01000,
        PH_IGNORE = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_VALID = 2'd1,
        ST_UNSAT = 2'd2
    } status_t;

    // Parse state as it stands after the final character of a header value.
    typedef struct packed {
        logic             form_ok;
        logic             has_first;
        logic             has_second;
        logic [VAL_W-1:0] first_value;
        logic [VAL_W-1:0] second_value;
    } snap_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] prefix_char(input logic [PCNT_W-1:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = "b";
            3'd1:    r = "y";
            3'd2:    r = "t";
            3'd3:    r = "e";
            3'd4:    r = "s";
            3'd5:    r = "=";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

### rtl/hbrp_ifs.sv
interface hbrp_cfg_if;
    import hbrp_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] file_size;
    modport source (output valid, output file_size, input ready);
    modport sink (input valid, input file_size, output ready);
endinterface

interface hbrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       char_valid;
    logic       last;
    modport source (output valid, output ch, output char_valid, output last, input ready);
    modport sink (input valid, input ch, input char_valid, input last, output ready);
endinterface

interface hbrp_out_if;
    import hbrp_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        range_status;
    logic [SIZE_W-1:0] range_start;
    logic [SIZE_W-1:0] range_end;
    modport source (output valid, output range_status, output range_start,
                    output range_end, input ready);
    modport sink (input valid, input range_status, input range_start,
                  input range_end, output ready);
endinterface

### rtl/hbrp_parser.sv
module hbrp_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      ch,
    input  logic            char_valid,
    input  logic            last,
    output hbrp_pkg::snap_t snap
);
    import hbrp_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] cnt;
        logic             gap;
        logic             bad;
    } side_t;

    phase_t             phase_reg, phase_next;
    logic [PCNT_W-1:0]  pcnt_reg, pcnt_next;
    side_t              first_reg, first_next;
    side_t              second_reg, second_next;
    logic               malformed_reg, malformed_next;

    // One character on one side of the dash: outer whitespace is skipped,
    // digits are gathered as value * 10 + digit.
    function automatic side_t side_step(input side_t s, input logic [7:0] c);
        side_t      r;
        logic [7:0] d;
        r = s;
        d = c - CH_ZERO;
        if (is_ws(c))
        begin
            if (s.cnt != '0)
            begin
                r.gap = 1'b1;
            end
        end
        else if (c < CH_ZERO || c > CH_NINE || s.gap || s.cnt >= MAX_DIGITS)
        begin
            r.bad = 1'b1;
        end
        else
        begin
            r.val = (s.val << 3) + (s.val << 1) + {{(VAL_W-4){1'b0}}, d[3:0]};
            r.cnt = s.cnt + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        logic [7:0] lc;
        side_t      sd;
        phase_next     = phase_reg;
        pcnt_next      = pcnt_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        malformed_next = malformed_reg;
        lc = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CASE_GAP : ch;
        sd = '0;

        if (take && char_valid)
        begin
            unique case (phase_reg)
                PH_LEAD, PH_PREFIX:
                begin
                    if (phase_reg == PH_LEAD && is_ws(ch))
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (lc != prefix_char(pcnt_reg))
                    begin
                        malformed_next = 1'b1;
                        phase_next     = PH_IGNORE;
                    end
                    else
                    begin
                        pcnt_next  = pcnt_reg + 1'b1;
                        phase_next = (pcnt_reg == PREFIX_LAST) ? PH_FIRST : PH_PREFIX;
                    end
                end
                PH_FIRST:
                begin
                    if (ch == CH_DASH)
                    begin
                        phase_next = PH_SECOND;
                    end
                    else if (ch == CH_COMMA)
                    begin
                        malformed_next = 1'b1;
                        phase_next     = PH_IGNORE;
                    end
                    else
                    begin
                        sd = side_step(first_reg, ch);
                        if (sd.bad)
                        begin
                            malformed_next = 1'b1;
                            phase_next     = PH_IGNORE;
                        end
                        else
                        begin
                            first_next = sd;
                        end
                    end
                end
                PH_SECOND:
                begin
                    if (ch == CH_COMMA)
                    begin
                        phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        sd = side_step(second_reg, ch);
                        if (sd.bad)
                        begin
                            malformed_next = 1'b1;
                            phase_next     = PH_IGNORE;
                        end
                        else
                        begin
                            second_next = sd;
                        end
                    end
                end
                PH_IGNORE:
                begin
                    phase_next = PH_IGNORE;
                end
                default:
                begin
                    phase_next = PH_LEAD;
                end
            endcase
        end

        // The snapshot sees the value after its final character.
        snap.form_ok      = !malformed_next &&
                            (phase_next == PH_SECOND || phase_next == PH_IGNORE);
        snap.has_first    = (first_next.cnt != '0);
        snap.has_second   = (second_next.cnt != '0);
        snap.first_value  = first_next.val;
        snap.second_value = second_next.val;

        if (take && last)
        begin
            phase_next     = PH_LEAD;
            pcnt_next      = '0;
            first_next     = '0;
            second_next    = '0;
            malformed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            pcnt_reg      <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            malformed_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pcnt_reg      <= pcnt_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            malformed_reg <= malformed_next;
        end
    end

endmodule

### rtl/hbrp_resolve.sv
module hbrp_resolve (
    input  logic [hbrp_pkg::SIZE_W-1:0] file_size,
    input  hbrp_pkg::snap_t             snap,
    output hbrp_pkg::status_t           status,
    output logic [hbrp_pkg::SIZE_W-1:0] start,
    output logic [hbrp_pkg::SIZE_W-1:0] stop
);
    import hbrp_pkg::*;

    logic [VAL_W-1:0]  f;
    logic [SIZE_W-1:0] f_m1;
    logic [VAL_W-1:0]  suffix_start;
    logic              f_zero;
    logic              second_ge_f;
    logic              first_ge_f;
    logic              reversed;

    assign f            = {1'b0, file_size};
    assign f_zero       = (file_size == '0);
    assign f_m1         = f_zero ? '0 : file_size - 1'b1;
    assign suffix_start = f - snap.second_value;
    assign second_ge_f  = (snap.second_value >= f);
    assign first_ge_f   = (snap.first_value >= f);
    assign reversed     = (snap.second_value < snap.first_value);

    always_comb
    begin
        status = ST_NONE;
        start  = '0;
        stop   = f_m1;
        if (snap.form_ok)
        begin
            if (!snap.has_first)
            begin
                // Suffix range: the last N bytes of the resource.
                if (!snap.has_second)
                begin
                    status = ST_NONE;
                end
                else if (snap.second_value == '0 || f_zero)
                begin
                    status = ST_UNSAT;
                end
                else
                begin
                    status = ST_VALID;
                    start  = second_ge_f ? '0 : suffix_start[SIZE_W-1:0];
                end
            end
            else if (snap.has_second && reversed)
            begin
                status = ST_NONE;
            end
            else if (first_ge_f)
            begin
                status = ST_UNSAT;
            end
            else
            begin
                status = ST_VALID;
                start  = snap.first_value[SIZE_W-1:0];
                // An open or overlong end is clamped to the last byte.
                stop   = (!snap.has_second || second_ge_f) ?
                         f_m1 : snap.second_value[SIZE_W-1:0];
            end
        end
    end

endmodule

### rtl/http_byte_range_parser_core.sv
// Channel | Direction | Payload                               | Handshake
// cfg     | in        | file_size                             | valid / ready
// din     | in        | ch, char_valid, last                  | valid / ready
// dout    | out       | range_status, range_start, range_end  | valid / ready
//
// One request is taken every cycle while results drain. The character is folded
// into the parse state in the cycle it is accepted; a final request hands a
// snapshot to a second register, and the range decision made on that snapshot
// is registered in the output stage.
// rst_n clears the parse state, the file size and both stage flags at once.
// A stalled output holds its result while the snapshot stage keeps one more;
// with both full, din.ready stays low until dout takes a result.
module http_byte_range_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    hbrp_cfg_if.sink          cfg,
    hbrp_in_if.sink           din,
    hbrp_out_if.source        dout
);
    import hbrp_pkg::*;

    logic [SIZE_W-1:0] file_size_reg;
    snap_t             snap;
    snap_t             snap_reg;
    logic              snap_v_reg, snap_v_next;
    logic              out_v_reg, out_v_next;
    status_t           status;
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] stop;
    status_t           out_status_reg;
    logic [SIZE_W-1:0] out_start_reg;
    logic [SIZE_W-1:0] out_end_reg;
    logic              out_free;
    logic              snap_move;
    logic              take;

    assign cfg.ready = 1'b1;
    assign out_free  = !out_v_reg || dout.ready;
    assign snap_move = snap_v_reg && out_free;
    assign din.ready = !snap_v_reg || out_free;
    assign take      = din.valid && din.ready;

    hbrp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .ch         (din.ch),
        .char_valid (din.char_valid),
        .last       (din.last),
        .snap       (snap)
    );

    hbrp_resolve u_resolve (
        .file_size (file_size_reg),
        .snap      (snap_reg),
        .status    (status),
        .start     (start),
        .stop      (stop)
    );

    always_comb
    begin
        snap_v_next = snap_v_reg;
        if (take && din.last)
        begin
            snap_v_next = 1'b1;
        end
        else if (snap_move)
        begin
            snap_v_next = 1'b0;
        end

        out_v_next = out_v_reg;
        if (snap_move)
        begin
            out_v_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            snap_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                file_size_reg <= cfg.file_size;
            end
            snap_v_reg <= snap_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && din.last)
        begin
            snap_reg <= snap;
        end
        if (snap_move)
        begin
            out_status_reg <= status;
            out_start_reg  <= start;
            out_end_reg    <= stop;
        end
    end

    assign dout.valid        = out_v_reg;
    assign dout.range_status = out_status_reg;
    assign dout.range_start  = out_start_reg;
    assign dout.range_end    = out_end_reg;

endmodule
